[rtl/core/wcs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wcs_pkg
// shared types, register indexes and state codes of the wash cycle sequencer
// ----------------------------------------------------------------------------
package wcs_pkg;

  localparam int CNT_W  = 22;
  localparam int TEMP_W = 10;
  localparam int DUTY_W = 8;
  localparam int CODE_W = 3;
  localparam int IDX_W  = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [DUTY_W-1:0] DUTY_FULL = {DUTY_W{1'b1}};
  localparam logic [DUTY_W-1:0] DUTY_OFF = '0;

  // register indexes
  localparam logic [IDX_W-1:0] REG_FILL_TIME        = 3'd0;
  localparam logic [IDX_W-1:0] REG_HEAT_THRESHOLD   = 3'd1;
  localparam logic [IDX_W-1:0] REG_AGITATE_PERIOD   = 3'd2;
  localparam logic [IDX_W-1:0] REG_WASH_NORMAL_TIME = 3'd3;
  localparam logic [IDX_W-1:0] REG_WASH_EXTRA_TIME  = 3'd4;
  localparam logic [IDX_W-1:0] REG_SPIN_TIME        = 3'd5;
  localparam logic [IDX_W-1:0] REG_SPIN_DUTY        = 3'd6;

  // reset values
  localparam logic [CNT_W-1:0]  RST_FILL_TIME        = 22'd300000;
  localparam logic [TEMP_W-1:0] RST_HEAT_THRESHOLD   = 10'd246;
  localparam logic [CNT_W-1:0]  RST_AGITATE_PERIOD   = 22'd10000;
  localparam logic [CNT_W-1:0]  RST_WASH_NORMAL_TIME = 22'd1800000;
  localparam logic [CNT_W-1:0]  RST_WASH_EXTRA_TIME  = 22'd2700000;
  localparam logic [CNT_W-1:0]  RST_SPIN_TIME        = 22'd900000;
  localparam logic [DUTY_W-1:0] RST_SPIN_DUTY        = 8'd230;

  // reported state codes
  localparam logic [CODE_W-1:0] CODE_IDLE  = 3'd0;
  localparam logic [CODE_W-1:0] CODE_FILL  = 3'd1;
  localparam logic [CODE_W-1:0] CODE_HEAT  = 3'd2;
  localparam logic [CODE_W-1:0] CODE_WASH  = 3'd3;
  localparam logic [CODE_W-1:0] CODE_SPIN  = 3'd4;
  localparam logic [CODE_W-1:0] CODE_DRAIN = 3'd5;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FILL  = 6'b000010,
    S_HEAT  = 6'b000100,
    S_WASH  = 6'b001000,
    S_SPIN  = 6'b010000,
    S_DRAIN = 6'b100000
  } state_t;

  typedef struct packed {
    logic              power_on;
    logic              start_level;
    logic              extra_wash;
    logic              full_level;
    logic [TEMP_W-1:0] temp_reading;
    logic              stop_request;
  } in_item_t;

  typedef struct packed {
    logic              heater_on;
    logic              door_lock;
    logic              drain_closed;
    logic              pump_on;
    logic [DUTY_W-1:0] motor_duty;
    logic [CODE_W-1:0] cycle_state;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]  fill_time;
    logic [TEMP_W-1:0] heat_threshold;
    logic [CNT_W-1:0]  agitate_period;
    logic [CNT_W-1:0]  wash_normal_time;
    logic [CNT_W-1:0]  wash_extra_time;
    logic [CNT_W-1:0]  spin_time;
    logic [DUTY_W-1:0] spin_duty;
  } cfg_t;

  typedef struct packed {
    logic             step;
    logic             clear;
    logic             use_now;
    logic [CNT_W-1:0] amount;
  } timer_ctl_t;

  function automatic logic [CODE_W-1:0] state_code(input state_t s);
    logic [CODE_W-1:0] c;
    case (s)
      S_FILL:  c = CODE_FILL;
      S_HEAT:  c = CODE_HEAT;
      S_WASH:  c = CODE_WASH;
      S_SPIN:  c = CODE_SPIN;
      S_DRAIN: c = CODE_DRAIN;
      default: c = CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/core/wcs_cfg_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wcs_cfg_regs
// configuration register file, written through the index/data channel
// ----------------------------------------------------------------------------
module wcs_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [wcs_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [wcs_pkg::CNT_W-1:0]  cfg_data,
  output wcs_pkg::cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fill_time        <= wcs_pkg::RST_FILL_TIME;
      cfg.heat_threshold   <= wcs_pkg::RST_HEAT_THRESHOLD;
      cfg.agitate_period   <= wcs_pkg::RST_AGITATE_PERIOD;
      cfg.wash_normal_time <= wcs_pkg::RST_WASH_NORMAL_TIME;
      cfg.wash_extra_time  <= wcs_pkg::RST_WASH_EXTRA_TIME;
      cfg.spin_time        <= wcs_pkg::RST_SPIN_TIME;
      cfg.spin_duty        <= wcs_pkg::RST_SPIN_DUTY;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wcs_pkg::REG_FILL_TIME:        cfg.fill_time        <= cfg_data;
        wcs_pkg::REG_HEAT_THRESHOLD:
          cfg.heat_threshold <= cfg_data[wcs_pkg::TEMP_W-1:0];
        wcs_pkg::REG_AGITATE_PERIOD:   cfg.agitate_period   <= cfg_data;
        wcs_pkg::REG_WASH_NORMAL_TIME: cfg.wash_normal_time <= cfg_data;
        wcs_pkg::REG_WASH_EXTRA_TIME:  cfg.wash_extra_time  <= cfg_data;
        wcs_pkg::REG_SPIN_TIME:        cfg.spin_time        <= cfg_data;
        wcs_pkg::REG_SPIN_DUTY:
          cfg.spin_duty <= cfg_data[wcs_pkg::DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/wcs_timer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wcs_timer
// one-shot tick timer: arms on first use, expires once when count > limit
// ----------------------------------------------------------------------------
module wcs_timer (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wcs_pkg::timer_ctl_t      ctl,
  output logic                     expired
);

  logic                      armed;
  logic [wcs_pkg::CNT_W-1:0] count;
  logic [wcs_pkg::CNT_W-1:0] limit;

  logic                      armed_next;
  logic [wcs_pkg::CNT_W-1:0] count_next;
  logic [wcs_pkg::CNT_W-1:0] limit_next;

  always_comb begin
    armed_next = armed;
    count_next = count;
    limit_next = limit;
    expired    = 1'b0;
    // tick first
    if (armed && count != wcs_pkg::CNT_MAX) begin
      count_next = count + 1'b1;
    end
    if (ctl.clear) begin
      armed_next = 1'b0;
      count_next = '0;
      limit_next = '0;
    end
    if (ctl.use_now) begin
      if (!armed_next) begin
        armed_next = 1'b1;
        limit_next = ctl.amount;
        count_next = '0;
      end else if (count_next > limit_next) begin
        armed_next = 1'b0;
        count_next = '0;
        expired    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b0;
      count <= '0;
      limit <= '0;
    end else if (ctl.step) begin
      armed <= armed_next;
      count <= count_next;
      limit <= limit_next;
    end
  end

endmodule
`default_nettype wire

[rtl/core/wash_cycle_sequencer.sv]
// path: a request is accepted into the input register, and its result is
// then written to the result register and shown from there
// throughput: one request per cycle unless out_stall holds the result register;
// the state, timer and motor-flag update of one request is done between the
// two registers
// reset: synchronous rst returns to idle, clears both timers and loads the default configuration
`default_nettype none
// ----------------------------------------------------------------------------
// wash_cycle_sequencer
// washing machine cycle controller stepped once per millisecond sample
// ----------------------------------------------------------------------------
module wash_cycle_sequencer (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wcs_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output wcs_pkg::out_item_t              out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [wcs_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [wcs_pkg::CNT_W-1:0]  cfg_data
);

  wcs_pkg::cfg_t       cfg;
  wcs_pkg::in_item_t   req;
  logic                req_valid;
  logic                adv;

  wcs_pkg::state_t     machine_state;
  wcs_pkg::state_t     st;
  wcs_pkg::state_t     machine_state_next;
  logic                agitate_motor_on;
  logic                agitate_motor_on_next;

  wcs_pkg::timer_ctl_t ctl_a;
  wcs_pkg::timer_ctl_t ctl_b;
  logic                exp_a;
  logic                exp_b;
  wcs_pkg::out_item_t  result;

  wcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wcs_timer u_timer_a (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl_a),
    .expired (exp_a)
  );

  wcs_timer u_timer_b (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl_b),
    .expired (exp_b)
  );

  // handshake
  assign adv      = req_valid && (!out_valid || !out_stall);
  assign in_stall = req_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req <= in_data;
    end
  end

  // stop forces drain before the state logic
  assign st = req.stop_request ? wcs_pkg::S_DRAIN : machine_state;

  // timer requests
  always_comb begin
    ctl_a.step    = adv;
    ctl_a.clear   = req.stop_request;
    ctl_a.use_now = 1'b0;
    ctl_a.amount  = cfg.fill_time;
    ctl_b.step    = adv;
    ctl_b.clear   = req.stop_request;
    ctl_b.use_now = 1'b0;
    ctl_b.amount  = cfg.spin_time;
    case (st)
      wcs_pkg::S_FILL: begin
        ctl_a.use_now = 1'b1;
      end
      wcs_pkg::S_WASH: begin
        ctl_a.use_now = 1'b1;
        ctl_a.amount  = cfg.agitate_period;
        ctl_b.use_now = 1'b1;
        ctl_b.amount  = req.extra_wash ? cfg.wash_extra_time : cfg.wash_normal_time;
      end
      wcs_pkg::S_SPIN: begin
        ctl_b.use_now = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // step logic
  always_comb begin
    machine_state_next    = st;
    agitate_motor_on_next = 1'b0;
    result.heater_on      = 1'b0;
    result.door_lock      = 1'b1;
    result.drain_closed   = 1'b1;
    result.pump_on        = 1'b0;
    result.motor_duty     = wcs_pkg::DUTY_OFF;
    case (st)
      wcs_pkg::S_FILL: begin
        result.pump_on = 1'b1;
        if (exp_a) begin
          machine_state_next = wcs_pkg::S_HEAT;
        end
      end
      wcs_pkg::S_HEAT: begin
        result.heater_on = 1'b1;
        if (req.temp_reading >= cfg.heat_threshold) begin
          machine_state_next = wcs_pkg::S_WASH;
        end
      end
      wcs_pkg::S_WASH: begin
        agitate_motor_on_next = agitate_motor_on ^ exp_a;
        result.motor_duty = agitate_motor_on_next ? wcs_pkg::DUTY_FULL : wcs_pkg::DUTY_OFF;
        if (exp_b) begin
          machine_state_next = wcs_pkg::S_SPIN;
        end
      end
      wcs_pkg::S_SPIN: begin
        result.motor_duty = cfg.spin_duty;
        if (exp_b) begin
          machine_state_next = wcs_pkg::S_DRAIN;
        end
      end
      wcs_pkg::S_DRAIN: begin
        result.drain_closed = 1'b0;
        if (!req.full_level) begin
          machine_state_next = wcs_pkg::S_IDLE;
        end
      end
      default: begin
        result.door_lock   = 1'b0;
        machine_state_next = wcs_pkg::S_IDLE;
        if (req.power_on && req.start_level) begin
          machine_state_next = wcs_pkg::S_FILL;
        end
      end
    endcase
    result.cycle_state = wcs_pkg::state_code(machine_state_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      machine_state    <= wcs_pkg::S_IDLE;
      agitate_motor_on <= 1'b0;
    end else if (adv) begin
      machine_state    <= machine_state_next;
      agitate_motor_on <= agitate_motor_on_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= result;
    end
  end

  // checks
  a_stop_drains: assert property (@(posedge clk) disable iff (rst)
    adv && req.stop_request |=>
      out_data.cycle_state == wcs_pkg::CODE_DRAIN ||
      out_data.cycle_state == wcs_pkg::CODE_IDLE)
    else $error("stop request did not lead to drain or idle");

  a_unlock_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.door_lock |->
      out_data.cycle_state == wcs_pkg::CODE_IDLE ||
      out_data.cycle_state == wcs_pkg::CODE_FILL)
    else $error("door unlocked outside idle");

  a_pump_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.pump_on |->
      out_data.cycle_state == wcs_pkg::CODE_FILL ||
      out_data.cycle_state == wcs_pkg::CODE_HEAT)
    else $error("pump on outside fill");

  // the flag may still be set on the step that leaves wash for spin
  a_motor_wash_only: assert property (@(posedge clk) disable iff (rst)
    agitate_motor_on |->
      machine_state == wcs_pkg::S_WASH || machine_state == wcs_pkg::S_SPIN)
    else $error("agitate flag set outside wash");

endmodule
`default_nettype wire
